[rtl/core/mvm_pkg.sv]
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiplier: channel
// payloads, operation and register codes, and the item formats passed
// between the front, the queue and the back.
// ----------------------------------------------------------------------------
package mvm_pkg;

   // configuration register width and limits
   localparam int CFG_W        = 11;
   localparam int CFG_MAX      = 2**CFG_W - 1;
   localparam int CFG_RESET    = 1024;
   localparam int CSR_IDX_W    = 2;

   // payload widths
   localparam int VALUE_W      = 16;
   localparam int PROD_W       = 2 * VALUE_W;
   localparam int SUM_W        = 48;
   localparam int ROW_IDX_W    = 10;

   // parameter defaults
   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;

   // queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = QPTR_W + 1;

   typedef enum logic {
      OP_VECTOR = 1'b0,
      OP_MATRIX = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_COLS = 2'd0,
      CSR_NUM_ROWS = 2'd1
   } csr_index_type;

   typedef struct packed {
      op_type                     operation;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]    row_sum;
      logic [ROW_IDX_W-1:0]       row_index;
      logic                       last_row;
   } rsp_type;

   // one matrix element with its vector element and row marks
   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic signed [VALUE_W-1:0]  vec;
      logic                       row_start;
      logic                       row_end;
      logic                       last_row;
      logic [ROW_IDX_W-1:0]       row_index;
   } work_type;

   // registered product with its row marks
   typedef struct packed {
      logic signed [PROD_W-1:0]   prod;
      logic                       row_start;
      logic                       row_end;
      logic                       last_row;
      logic [ROW_IDX_W-1:0]       row_index;
   } mul_type;

endpackage

[rtl/core/mvm_front.sv]
// ----------------------------------------------------------------------------
// mvm_front
// Accepts items, keeps the vector store and the column, row and fill
// positions, holds the configuration, and hands matrix items with their
// vector element to the queue.
// ----------------------------------------------------------------------------
module mvm_front #(
   parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mvm_pkg::CFG_W-1:0]       csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mvm_pkg::req_type                req_data,
   output logic                            work_valid,
   input  logic                            work_ready,
   output mvm_pkg::work_type               work_data
);
   import mvm_pkg::*;

   localparam int COL_LIM  = (MAX_COLS < CFG_MAX) ? MAX_COLS : CFG_MAX;
   localparam int ROW_LIM  = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
   localparam int ADDR_W   = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
   localparam int ROW_W    = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
   localparam int COLS_RST = (CFG_RESET < COL_LIM) ? CFG_RESET : COL_LIM;
   localparam int ROWS_RST = (CFG_RESET < ROW_LIM) ? CFG_RESET : ROW_LIM;
   localparam logic [CFG_W-1:0] COL_LIM_V = CFG_W'(COL_LIM);
   localparam logic [CFG_W-1:0] ROW_LIM_V = CFG_W'(ROW_LIM);

   logic [CFG_W-1:0]          eff_cols_ff, eff_cols_in;
   logic [CFG_W-1:0]          eff_rows_ff, eff_rows_in;
   logic [ADDR_W-1:0]         fill_ff, fill_in;
   logic [ADDR_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      stage_valid_ff, stage_valid_in;
   work_type                  stage_ff;
   logic [VALUE_W-1:0]        rd_data_ff;
   logic [VALUE_W-1:0]        vec_mem [COL_LIM];

   logic                      accept;
   logic                      accept_load;
   logic                      accept_matrix;
   logic [CFG_W:0]            col_next;
   logic [CFG_W:0]            fill_next;
   logic [CFG_W:0]            row_next;
   logic                      row_end;
   logic                      last_row;

   assign csr_ready     = 1'b1;
   assign req_ready     = !stage_valid_ff || work_ready;
   assign accept        = req_valid && req_ready;
   assign accept_load   = accept && (req_data.operation == OP_VECTOR);
   assign accept_matrix = accept && (req_data.operation == OP_MATRIX);

   assign col_next  = (CFG_W+1)'(col_ff) + (CFG_W+1)'(1);
   assign fill_next = (CFG_W+1)'(fill_ff) + (CFG_W+1)'(1);
   assign row_next  = (CFG_W+1)'(row_ff) + (CFG_W+1)'(1);
   assign row_end   = col_next >= {1'b0, eff_cols_ff};
   assign last_row  = row_next >= {1'b0, eff_rows_ff};

   // configuration, clamped to the supported range on write
   always_comb begin
      eff_cols_in = eff_cols_ff;
      eff_rows_in = eff_rows_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_COLS: begin
               if (csr_data == '0)             eff_cols_in = CFG_W'(1);
               else if (csr_data > COL_LIM_V)  eff_cols_in = COL_LIM_V;
               else                            eff_cols_in = csr_data;
            end
            CSR_NUM_ROWS: begin
               if (csr_data == '0)             eff_rows_in = CFG_W'(1);
               else if (csr_data > ROW_LIM_V)  eff_rows_in = ROW_LIM_V;
               else                            eff_rows_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // positions
   always_comb begin
      fill_in = fill_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept_load) begin
         fill_in = (fill_next >= {1'b0, eff_cols_ff}) ? '0 : ADDR_W'(fill_next);
         col_in  = '0;
         row_in  = '0;
      end else if (accept_matrix) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : ROW_W'(row_next);
         end else begin
            col_in = ADDR_W'(col_next);
         end
      end
   end

   always_comb begin
      if (accept_matrix)   stage_valid_in = 1'b1;
      else if (work_ready) stage_valid_in = 1'b0;
      else                 stage_valid_in = stage_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_cols_ff    <= CFG_W'(COLS_RST);
         eff_rows_ff    <= CFG_W'(ROWS_RST);
         fill_ff        <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         eff_cols_ff    <= eff_cols_in;
         eff_rows_ff    <= eff_rows_in;
         fill_ff        <= fill_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_matrix) begin
         stage_ff.value     <= req_data.value;
         stage_ff.vec       <= '0;
         stage_ff.row_start <= (col_ff == '0);
         stage_ff.row_end   <= row_end;
         stage_ff.last_row  <= row_end && last_row;
         stage_ff.row_index <= ROW_IDX_W'(row_ff);
      end
   end

   // vector store: write on loads, read for matrix items
   always_ff @(posedge clock) begin
      if (accept_load) begin
         vec_mem[fill_ff] <= req_data.value;
      end
      if (accept_matrix) begin
         rd_data_ff <= vec_mem[col_ff];
      end
   end

   assign work_valid = stage_valid_ff;

   always_comb begin
      work_data     = stage_ff;
      work_data.vec = rd_data_ff;
   end

endmodule

[rtl/core/mvm_queue.sv]
// ----------------------------------------------------------------------------
// mvm_queue
// Short first-in first-out queue between the front and the back, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module mvm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mvm_pkg::work_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output mvm_pkg::work_type   out_data
);
   import mvm_pkg::*;

   work_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[rtl/core/mvm_back.sv]
// ----------------------------------------------------------------------------
// mvm_back
// Multiplies each matrix element by its vector element, accumulates the
// products of a row, and holds each finished row sum in the result register.
// ----------------------------------------------------------------------------
module mvm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   output logic                work_ready,
   input  mvm_pkg::work_type   work_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mvm_pkg::rsp_type    rsp_data
);
   import mvm_pkg::*;

   logic                      mul_valid_ff, mul_valid_in;
   mul_type                   mul_ff;
   logic signed [SUM_W-1:0]   acc_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff;

   logic signed [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]   acc_base;
   logic signed [SUM_W-1:0]   sum;
   logic                      out_free;
   logic                      mul_adv;

   assign prod       = work_data.value * work_data.vec;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign mul_adv    = mul_valid_ff && (!mul_ff.row_end || out_free);
   assign work_ready = !mul_valid_ff || mul_adv;

   // first column of a row starts a fresh sum
   assign acc_base = mul_ff.row_start ? '0 : acc_ff;
   assign sum      = acc_base + {{(SUM_W-PROD_W){mul_ff.prod[PROD_W-1]}}, mul_ff.prod};

   always_comb begin
      mul_valid_in = work_ready ? work_valid : mul_valid_ff;
      if (mul_adv && mul_ff.row_end) rsp_valid_in = 1'b1;
      else if (rsp_ready)            rsp_valid_in = 1'b0;
      else                           rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_valid && work_ready) begin
         mul_ff.prod      <= prod;
         mul_ff.row_start <= work_data.row_start;
         mul_ff.row_end   <= work_data.row_end;
         mul_ff.last_row  <= work_data.last_row;
         mul_ff.row_index <= work_data.row_index;
      end
      if (mul_adv) begin
         acc_ff <= sum;
      end
      if (mul_adv && mul_ff.row_end) begin
         rsp_ff.row_sum   <= sum;
         rsp_ff.row_index <= mul_ff.row_index;
         rsp_ff.last_row  <= mul_ff.last_row;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/matrix_vector_multiply.sv]
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Dense matrix-vector product in signed Q8.8 with an exact Q32.16 row sum.
// ----------------------------------------------------------------------------
// Items arrive on req_*: a vector load writes the next vector element and
// restarts the matrix at row 0, column 0; a matrix element streams in
// row-major order. After the last column of a row one result leaves on
// rsp_*: the row sum, its row index and a flag on the final row.
// The user must write registers num_cols and num_rows on csr_* only while
// idle; the block itself does not enforce this. num_cols is clamped to 1
// up to the store depth, num_rows to 1 up to the lesser of MAX_ROWS and 2047.
// Front and back each take one item a cycle unless stalled, so throughput is
// one item per cycle; the vector store has one write and one read port.
// The last element of a row passes the front stage, the queue and the multiply
// register, then the accumulate writes the result register and sets rsp_valid.
// Reset clears all positions, the queue and the result valid flag and sets both
// registers to 1024 or their lower limit; the vector store is not cleared.
// When rsp_ready is low the result holds, the back stops, the queue fills
// and then req_ready falls.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
   parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mvm_pkg::CFG_W-1:0]       csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mvm_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mvm_pkg::rsp_type                rsp_data
);
   import mvm_pkg::*;

   logic       front_valid;
   logic       front_ready;
   work_type   front_data;
   logic       back_valid;
   logic       back_ready;
   work_type   back_data;

   mvm_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .work_valid (front_valid),
      .work_ready (front_ready),
      .work_data  (front_data)
   );

   mvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   mvm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (back_valid),
      .work_ready (back_ready),
      .work_data  (back_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
